/* design/hte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID touch report extractor package
// Shared types and codes for the touch report extractor.
// ----------------------------------------------------------------------------
package hte_pkg;

   // item actions
   localparam logic [1:0] ACT_OCTET = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_MAX_LEN  = 3'd0;
   localparam logic [2:0] CSR_USES_ID  = 3'd1;
   localparam logic [2:0] CSR_WANT_ID  = 3'd2;
   localparam logic [2:0] CSR_TIP_OFF  = 3'd3;
   localparam logic [2:0] CSR_X_OFF    = 3'd4;
   localparam logic [2:0] CSR_X_SIZE   = 3'd5;
   localparam logic [2:0] CSR_Y_OFF    = 3'd6;
   localparam logic [2:0] CSR_Y_SIZE   = 3'd7;

   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;

   // smallest valid report length, header included
   localparam logic [15:0] MIN_REPORT_LEN = 16'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_octet;
      logic       end_of_read;
   } req_payload_type;

   typedef struct packed {
      logic        fresh;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic        touching;
   } rsp_payload_type;

   typedef struct packed {
      logic [8:0]  max_input_length;
      logic        uses_report_id;
      logic [7:0]  wanted_report_id;
      logic [10:0] tip_offset;
      logic [10:0] x_offset;
      logic [5:0]  x_size;
      logic [10:0] y_offset;
      logic [5:0]  y_size;
   } cfg_type;

   // outcome of a finished read
   typedef struct packed {
      logic        update;
      logic        tip;
      logic [31:0] x;
      logic [31:0] y;
   } report_type;

endpackage

/* design/hte_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transfer from a source to a sink.
// ----------------------------------------------------------------------------
interface hte_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/hid_touch_report_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID touch report extractor
// Parses raw HID-over-I2C input reads into a pointer position and touch flag.
// ----------------------------------------------------------------------------
// Takes one item per clock: a raw read byte, a clear or a query. Each item is
// held in an input register, then the parser and pointer state act on it and
// a query drops its answer into the result register, which drives the result
// channel. Only the result register can stall the flow, and only for queries.
// Configuration registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module hid_touch_report_extractor #(
   parameter int MAX_REPORT_BYTES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   hte_chan_if.sink                          req_chan,
   hte_chan_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [hte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hte_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hte_pkg::*;

   localparam logic [8:0] READ_CAP =
      (MAX_REPORT_BYTES > 511) ? 9'd511 : 9'(MAX_REPORT_BYTES);

   cfg_type         cfg_ff;
   logic [8:0]      eff_max;

   logic            s1_valid_ff;
   req_payload_type s1_item_ff;
   logic            out_free;
   logic            s2_go;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [31:0]     cur_x_ff, cur_x_in;
   logic [31:0]     cur_y_ff, cur_y_in;
   logic            active_ff, active_in;
   logic            changed_ff, changed_in;
   logic            prior_ff, prior_in;
   rsp_payload_type rsp_data_in;

   report_type      report;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_input_length <= 9'd256;
         cfg_ff.uses_report_id   <= 1'b0;
         cfg_ff.wanted_report_id <= 8'd0;
         cfg_ff.tip_offset       <= 11'd0;
         cfg_ff.x_offset         <= 11'd0;
         cfg_ff.x_size           <= 6'd16;
         cfg_ff.y_offset         <= 11'd0;
         cfg_ff.y_size           <= 6'd16;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_LEN: cfg_ff.max_input_length <= csr_data[8:0];
            CSR_USES_ID: cfg_ff.uses_report_id   <= csr_data[0];
            CSR_WANT_ID: cfg_ff.wanted_report_id <= csr_data[7:0];
            CSR_TIP_OFF: cfg_ff.tip_offset       <= csr_data[10:0];
            CSR_X_OFF:   cfg_ff.x_offset         <= csr_data[10:0];
            CSR_X_SIZE:  cfg_ff.x_size           <= csr_data[5:0];
            CSR_Y_OFF:   cfg_ff.y_offset         <= csr_data[10:0];
            CSR_Y_SIZE:  cfg_ff.y_size           <= csr_data[5:0];
         endcase
      end
   end

   assign eff_max = (cfg_ff.max_input_length > READ_CAP) ? READ_CAP
                                                         : cfg_ff.max_input_length;

   // input register; only a query waits on the result register
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s2_go          = s1_valid_ff && (s1_item_ff.action != ACT_QUERY || out_free);
   assign req_chan.ready = !s1_valid_ff || s2_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_item_ff <= req_chan.data;
      end
   end

   hte_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (s2_go && s1_item_ff.action == ACT_OCTET),
      .octet   (s1_item_ff.data_octet),
      .last    (s1_item_ff.end_of_read),
      .eff_max (eff_max),
      .cfg     (cfg_ff),
      .report  (report)
   );

   // pointer state and query answer
   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      active_in   = active_ff;
      changed_in  = changed_ff;
      prior_in    = prior_ff;
      rsp_data_in = '0;
      if (s2_go) begin
         unique case (s1_item_ff.action)
            ACT_OCTET: begin
               // update on touch, or once on the first release
               if (report.update && (report.tip || prior_ff)) begin
                  if (report.tip) begin
                     cur_x_in = report.x;
                     cur_y_in = report.y;
                  end
                  active_in  = report.tip;
                  changed_in = 1'b1;
                  prior_in   = report.tip;
               end
            end
            ACT_CLEAR: begin
               cur_x_in   = '0;
               cur_y_in   = '0;
               active_in  = 1'b0;
               changed_in = 1'b0;
               prior_in   = 1'b0;
            end
            ACT_QUERY: begin
               if (changed_ff) begin
                  rsp_data_in.fresh    = 1'b1;
                  rsp_data_in.pos_x    = cur_x_ff;
                  rsp_data_in.pos_y    = cur_y_ff;
                  rsp_data_in.touching = active_ff;
                  changed_in           = 1'b0;
               end
            end
            default: begin
               // unused action: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         active_ff  <= 1'b0;
         changed_ff <= 1'b0;
         prior_ff   <= 1'b0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         active_ff  <= active_in;
         changed_ff <= changed_in;
         prior_ff   <= prior_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && s1_item_ff.action == ACT_QUERY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s1_item_ff.action == ACT_QUERY) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

/* design/hte_field_place.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Field bit placement
// Maps the bits of one payload byte onto a field of programmed offset and size.
// ----------------------------------------------------------------------------
module hte_field_place (
   input  logic [11:0] pbase,
   input  logic [7:0]  octet,
   input  logic [10:0] offset,
   input  logic [5:0]  size,
   output logic [31:0] contrib
);
   import hte_pkg::*;

   logic [13:0] shift_amt;
   logic [46:0] wide;
   logic [5:0]  size_eff;
   logic [31:0] mask;

   always_comb begin
      // field bit j takes byte bit (j - (pbase - offset)); bias by 7 to stay positive
      shift_amt = {2'b00, pbase} - {3'b000, offset} + 14'd7;
      wide      = {39'd0, octet} << shift_amt[5:0];
      size_eff  = (size > 6'd32) ? 6'd32 : size;
      for (int j = 0; j < 32; j++) begin
         mask[j] = (6'(j) < size_eff);
      end
      if (shift_amt < 14'd39) begin
         contrib = wide[38:7] & mask;
      end else begin
         contrib = '0;
      end
   end

endmodule

/* design/hte_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input read parser
// Tracks the bytes of one raw read, gathers tip, X and Y, and checks the
// report at the last byte.
// ----------------------------------------------------------------------------
module hte_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          octet,
   input  logic                last,
   input  logic [8:0]          eff_max,
   input  hte_pkg::cfg_type    cfg,
   output hte_pkg::report_type report
);
   import hte_pkg::*;

   logic [8:0]  idx_ff, idx_in;
   logic [15:0] len_ff, len_in;
   logic        id_ff, id_in;
   logic        tip_ff, tip_in;
   logic [31:0] xg_ff, xg_in;
   logic [31:0] yg_ff, yg_in;

   logic [8:0]  start;
   logic [8:0]  rel;
   logic [11:0] pbase;
   logic [13:0] tip_rel;
   logic [31:0] x_contrib;
   logic [31:0] y_contrib;

   assign start = cfg.uses_report_id ? 9'd3 : 9'd2;
   assign rel   = idx_ff - start;
   assign pbase = {rel, 3'b000};

   hte_field_place u_x_place (
      .pbase   (pbase),
      .octet   (octet),
      .offset  (cfg.x_offset),
      .size    (cfg.x_size),
      .contrib (x_contrib)
   );

   hte_field_place u_y_place (
      .pbase   (pbase),
      .octet   (octet),
      .offset  (cfg.y_offset),
      .size    (cfg.y_size),
      .contrib (y_contrib)
   );

   always_comb begin
      logic        first;
      logic [8:0]  idx_next;
      logic [8:0]  got;
      logic        id_ok;
      logic        valid_rep;

      first   = (idx_ff == 9'd0);
      // a new read starts from cleared gathering state
      len_in  = first ? '0 : len_ff;
      id_in   = first ? 1'b0 : id_ff;
      tip_in  = first ? 1'b0 : tip_ff;
      xg_in   = first ? '0 : xg_ff;
      yg_in   = first ? '0 : yg_ff;
      tip_rel = {3'b000, cfg.tip_offset} - {2'b00, pbase};

      if (idx_ff < eff_max) begin
         if (idx_ff == 9'd0) begin
            len_in = {8'd0, octet};
         end else if (idx_ff == 9'd1) begin
            len_in = len_in | {octet, 8'd0};
         end else if (cfg.uses_report_id && idx_ff == 9'd2) begin
            id_in = (octet == cfg.wanted_report_id);
         end else if (idx_ff >= start && {7'd0, idx_ff} < len_in) begin
            if (tip_rel[13:3] == '0 && octet[tip_rel[2:0]]) begin
               tip_in = 1'b1;
            end
            xg_in = xg_in | x_contrib;
            yg_in = yg_in | y_contrib;
         end
      end

      // index saturates at its top value
      idx_next = (idx_ff == 9'h1FF) ? idx_ff : idx_ff + 9'd1;

      got       = (idx_next > eff_max) ? eff_max : idx_next;
      id_ok     = (got > 9'd2) ? id_in : (cfg.wanted_report_id == 8'd0);
      valid_rep = (len_in >= MIN_REPORT_LEN) &&
                  (len_in <= {7'd0, cfg.max_input_length}) &&
                  (!cfg.uses_report_id || id_ok);

      idx_in        = last ? 9'd0 : idx_next;
      report.update = take && last && valid_rep;
      report.tip    = tip_in;
      report.x      = xg_in;
      report.y      = yg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         len_ff <= len_in;
         id_ff  <= id_in;
         tip_ff <= tip_in;
         xg_ff  <= xg_in;
         yg_ff  <= yg_in;
      end
   end

endmodule

/* design/hte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report extractor port checker
// Watches the result channel of the extractor over time.
// ----------------------------------------------------------------------------
module hte_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fresh,
   input logic [31:0] rsp_pos_x,
   input logic [31:0] rsp_pos_y,
   input logic        rsp_touching
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_fresh) && $stable(rsp_pos_x) &&
                                  $stable(rsp_pos_y) && $stable(rsp_touching))
      else $error("stalled result changed");

   // a stale answer carries no position
   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fresh |-> rsp_pos_x == 32'd0 && rsp_pos_y == 32'd0 &&
                                  !rsp_touching)
      else $error("stale answer with nonzero fields");

   a_touch_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_touching |-> rsp_fresh)
      else $error("touch reported without change");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hid_touch_report_extractor hte_checker u_hte_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_fresh    (rsp_chan.data.fresh),
   .rsp_pos_x    (rsp_chan.data.pos_x),
   .rsp_pos_y    (rsp_chan.data.pos_y),
   .rsp_touching (rsp_chan.data.touching)
);
